// File: hdl/qoa_pkg.sv
package qoa_pkg;

  // Component and datapath widths
  localparam int QW     = 16;          // Q2.14 component
  localparam int FRAC   = 14;          // fractional bits
  localparam int WW     = 20;          // rounded, unsaturated component
  localparam int PW     = 2 * WW;      // multiplier product
  localparam int AW     = PW + 1;      // accumulator
  localparam int RW     = PW;          // root / divide working registers
  localparam int CNT_W  = 10;          // compose counter and interval

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int DW     = 32;
  localparam logic REG_RENORM = 1'b0;  // register index, paddr[2]
  localparam logic [CNT_W-1:0] RENORM_RST = 10'd97;

  localparam logic signed [QW-1:0] QONE = 16'sd16384;

  // Component indices
  localparam logic [1:0] C_X = 2'd0;
  localparam logic [1:0] C_Y = 2'd1;
  localparam logic [1:0] C_Z = 2'd2;
  localparam logic [1:0] C_W = 2'd3;

  // Control of one multiply-accumulate beat
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic neg;
  } mac_ctrl_t;

  // One product term of the quaternion product: d[d_idx] * o[o_idx]
  typedef struct packed {
    logic [1:0] d_idx;
    logic [1:0] o_idx;
    logic       neg;
  } term_t;

  // Four terms per result component, x y z w in order
  function automatic term_t term_sel(input logic [3:0] t);
    term_t r;
    unique case (t)
      4'd0:  r = '{d_idx: C_X, o_idx: C_W, neg: 1'b0};
      4'd1:  r = '{d_idx: C_W, o_idx: C_X, neg: 1'b0};
      4'd2:  r = '{d_idx: C_Z, o_idx: C_Y, neg: 1'b0};
      4'd3:  r = '{d_idx: C_Y, o_idx: C_Z, neg: 1'b1};
      4'd4:  r = '{d_idx: C_Y, o_idx: C_W, neg: 1'b0};
      4'd5:  r = '{d_idx: C_W, o_idx: C_Y, neg: 1'b0};
      4'd6:  r = '{d_idx: C_X, o_idx: C_Z, neg: 1'b0};
      4'd7:  r = '{d_idx: C_Z, o_idx: C_X, neg: 1'b1};
      4'd8:  r = '{d_idx: C_Z, o_idx: C_W, neg: 1'b0};
      4'd9:  r = '{d_idx: C_W, o_idx: C_Z, neg: 1'b0};
      4'd10: r = '{d_idx: C_Y, o_idx: C_X, neg: 1'b0};
      4'd11: r = '{d_idx: C_X, o_idx: C_Y, neg: 1'b1};
      4'd12: r = '{d_idx: C_W, o_idx: C_W, neg: 1'b0};
      4'd13: r = '{d_idx: C_X, o_idx: C_X, neg: 1'b1};
      4'd14: r = '{d_idx: C_Y, o_idx: C_Y, neg: 1'b1};
      4'd15: r = '{d_idx: C_Z, o_idx: C_Z, neg: 1'b1};
      default: r = '{d_idx: C_X, o_idx: C_X, neg: 1'b0};
    endcase
    return r;
  endfunction

endpackage

// File: hdl/qoa_mac.sv
// Shared multiply-accumulate: registered product, then accumulate.
// Sum is on acc_o while done_o is high, after the product and accumulator registers.
module qoa_mac
  import qoa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_ctrl_t            ctrl_i,
  input  logic signed [WW-1:0] a_i,
  input  logic signed [WW-1:0] b_i,
  output logic signed [AW-1:0] acc_o,
  output logic                 done_o
);

  mac_ctrl_t            ctrl_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [AW-1:0] acc_q, acc_d, base;
  logic                 done_q, done_d;

  always_comb begin
    prod_d = a_i * b_i;
    base   = ctrl_q.first ? '0 : acc_q;
    acc_d  = acc_q;
    if (ctrl_q.vld) begin
      acc_d = ctrl_q.neg ? base - AW'(prod_q) : base + AW'(prod_q);
    end
    done_d = ctrl_q.vld & ctrl_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctrl_q <= ctrl_i;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// File: hdl/quaternion_orientation_accumulator.sv
// A load beat goes straight to the output register; a compose runs 16 product
// terms through the MAC, and a renormalising one adds sum of squares, root and
// divide; an output stall can hold any result. One item at a time: the next beat
// is taken the cycle after the result is registered.
// One shared 20x20 MAC; root and divide share one compare-subtract unit.
// Reset (async, active low): orientation identity, count 0, interval 97.
module quaternion_orientation_accumulator
  import qoa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [DW-1:0]        pwdata,
  output logic [DW-1:0]        prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic signed [QW-1:0] in_x_i,
  input  logic signed [QW-1:0] in_y_i,
  input  logic signed [QW-1:0] in_z_i,
  input  logic signed [QW-1:0] in_w_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [QW-1:0] out_x_o,
  output logic signed [QW-1:0] out_y_o,
  output logic signed [QW-1:0] out_z_o,
  output logic signed [QW-1:0] out_w_o,
  output logic                 renormalized_o,
  output logic                 saturated_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a beat
  localparam logic [2:0] S_MUL  = 3'd1;  // 16 product terms through the MAC
  localparam logic [2:0] S_SQ   = 3'd2;  // sum of squares
  localparam logic [2:0] S_SQRT = 3'd3;  // bit-serial integer root
  localparam logic [2:0] S_DIV  = 3'd4;  // restoring divide, one component at a time
  localparam logic [2:0] S_DONE = 3'd5;  // saturate, hand to output register

  localparam int SQRT_STEPS = WW;         // one result bit per step
  localparam int DIV_STEPS  = FRAC + 1;   // quotient never exceeds 1.0
  localparam int NUM_TERMS  = 16;
  localparam logic [RW-1:0] SQRT_TOP = RW'(1) << (2 * (WW - 1));

  typedef struct packed {
    logic signed [QW-1:0] val;
    logic                 clip;
  } sat_t;

  // Round Q28 sum to Q14, nearest, ties away from zero
  function automatic logic signed [WW-1:0] round_q14(input logic signed [AW-1:0] v);
    logic [AW-1:0] mag;
    logic [AW-1:0] rnd;
    logic [WW-1:0] q;
    mag = v[AW-1] ? AW'(-v) : AW'(v);
    rnd = mag + (AW'(1) << (FRAC - 1));
    q   = rnd[WW+FRAC-1:FRAC];
    return v[AW-1] ? $signed(-q) : $signed(q);
  endfunction

  function automatic sat_t sat16(input logic signed [WW-1:0] v);
    sat_t r;
    if (v > WW'(32767)) begin
      r = '{val: 16'sh7fff, clip: 1'b1};
    end else if (v < -$signed(WW'(32768))) begin
      r = '{val: 16'sh8000, clip: 1'b1};
    end else begin
      r = '{val: v[QW-1:0], clip: 1'b0};
    end
    return r;
  endfunction

  // Control state
  logic [2:0]        state_q, state_d;
  logic [4:0]        term_q, term_d;     // issue count, up to NUM_TERMS
  logic [2:0]        cap_q, cap_d;       // captured sums, up to 4
  logic [4:0]        step_q, step_d;
  logic [1:0]        comp_q, comp_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  interval_q, interval_d;
  logic              renorm_q, renorm_d;
  logic              out_valid_q, out_valid_d;
  logic signed [QW-1:0] orient_q [4];
  logic signed [QW-1:0] orient_d [4];

  // Datapath
  logic signed [QW-1:0] din_q [4];
  logic signed [QW-1:0] din_d [4];
  logic signed [WW-1:0] wide_q [4];
  logic signed [WW-1:0] wide_d [4];
  logic [RW-1:0]        rem_q, rem_d;    // root radicand / divide remainder
  logic [RW-1:0]        dvs_q, dvs_d;    // root partial result / shifted divisor
  logic [RW-1:0]        bit_q, bit_d;
  logic [DIV_STEPS-1:0] quo_q, quo_d;
  logic [WW-1:0]        norm_q, norm_d;
  logic signed [QW-1:0] out_q [4];
  logic signed [QW-1:0] out_d [4];
  logic                 out_renorm_q, out_renorm_d;
  logic                 out_sat_q, out_sat_d;

  // Shared MAC
  mac_ctrl_t            mac_ctrl;
  logic signed [WW-1:0] mac_a, mac_b;
  logic signed [AW-1:0] mac_acc;
  logic                 mac_done;

  qoa_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  // Shared compare-subtract: root step adds the trial bit first
  logic [RW-1:0] cs_b, cs_diff, res_nx;
  logic          cs_ge;

  always_comb begin
    cs_b    = (state_q == S_SQRT) ? dvs_q + bit_q : dvs_q;
    cs_ge   = rem_q >= cs_b;
    cs_diff = rem_q - cs_b;
    res_nx  = cs_ge ? (dvs_q >> 1) + bit_q : dvs_q >> 1;
  end

  term_t                sel;
  logic [CNT_W:0]       next_cnt;
  logic [WW-1:0]        abs_w;
  logic [DIV_STEPS-1:0] quo_nx;
  logic [WW-1:0]        quo_w;
  sat_t                 sat [4];
  logic                 any_clip;

  always_comb begin
    sel      = term_sel(term_q[3:0]);
    next_cnt = {1'b0, count_q} + (CNT_W+1)'(1);
    abs_w    = wide_q[comp_q][WW-1] ? WW'(-wide_q[comp_q]) : WW'(wide_q[comp_q]);
    quo_nx   = {quo_q[DIV_STEPS-2:0], cs_ge};
    quo_w    = WW'(quo_nx);
    any_clip = 1'b0;
    for (int i = 0; i < 4; i++) begin
      sat[i]   = sat16(wide_q[i]);
      any_clip = any_clip | sat[i].clip;
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    term_d       = term_q;
    cap_d        = cap_q;
    step_d       = step_q;
    comp_d       = comp_q;
    count_d      = count_q;
    interval_d   = interval_q;
    renorm_d     = renorm_q;
    out_valid_d  = out_valid_q;
    rem_d        = rem_q;
    dvs_d        = dvs_q;
    bit_d        = bit_q;
    quo_d        = quo_q;
    norm_d       = norm_q;
    out_renorm_d = out_renorm_q;
    out_sat_d    = out_sat_q;
    for (int i = 0; i < 4; i++) begin
      orient_d[i] = orient_q[i];
      din_d[i]    = din_q[i];
      wide_d[i]   = wide_q[i];
      out_d[i]    = out_q[i];
    end
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;

    if (psel && penable && pwrite && (paddr[CFG_AW-1] == REG_RENORM)) begin
      interval_d = pwdata[CNT_W-1:0];
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          din_d[C_X] = in_x_i;
          din_d[C_Y] = in_y_i;
          din_d[C_Z] = in_z_i;
          din_d[C_W] = in_w_i;
          term_d     = '0;
          cap_d      = '0;
          if (func_i) begin
            // load: result is the beat itself
            wide_d[C_X] = WW'(in_x_i);
            wide_d[C_Y] = WW'(in_y_i);
            wide_d[C_Z] = WW'(in_z_i);
            wide_d[C_W] = WW'(in_w_i);
            renorm_d    = 1'b0;
            state_d     = S_DONE;
          end else begin
            state_d = S_MUL;
          end
        end
      end

      S_MUL: begin
        if (term_q < 5'(NUM_TERMS)) begin
          mac_ctrl = '{vld: 1'b1, first: (term_q[1:0] == 2'd0),
                       last: (term_q[1:0] == 2'd3), neg: sel.neg};
          mac_a    = WW'(din_q[sel.d_idx]);
          mac_b    = WW'(orient_q[sel.o_idx]);
          term_d   = term_q + 5'd1;
        end
        if (mac_done) begin
          wide_d[cap_q[1:0]] = round_q14(mac_acc);
          cap_d              = cap_q + 3'd1;
        end
        if (cap_q[2]) begin
          if (next_cnt > {1'b0, interval_q}) begin
            count_d  = '0;
            renorm_d = 1'b1;
            term_d   = '0;
            state_d  = S_SQ;
          end else begin
            count_d  = next_cnt[CNT_W-1:0];
            renorm_d = 1'b0;
            state_d  = S_DONE;
          end
        end
      end

      S_SQ: begin
        if (!term_q[2]) begin
          mac_ctrl = '{vld: 1'b1, first: (term_q[1:0] == 2'd0),
                       last: (term_q[1:0] == 2'd3), neg: 1'b0};
          mac_a    = wide_q[term_q[1:0]];
          mac_b    = wide_q[term_q[1:0]];
          term_d   = term_q + 5'd1;
        end
        if (mac_done) begin
          rem_d   = mac_acc[RW-1:0];
          dvs_d   = '0;
          bit_d   = SQRT_TOP;
          step_d  = '0;
          state_d = S_SQRT;
        end
      end

      S_SQRT: begin
        rem_d  = cs_ge ? cs_diff : rem_q;
        dvs_d  = res_nx;
        bit_d  = bit_q >> 2;
        step_d = step_q + 5'd1;
        if (step_q == 5'(SQRT_STEPS - 1)) begin
          norm_d = res_nx[WW-1:0];
          step_d = '0;
          comp_d = '0;
          if (res_nx == '0) begin
            // all-zero product: nothing to divide by, result stays zero
            for (int i = 0; i < 4; i++) begin
              wide_d[i] = '0;
            end
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (step_q == '0) begin
          // numerator |v|*2^14 + norm/2, divisor aligned to quotient bit 14
          rem_d  = RW'({abs_w, {FRAC{1'b0}}}) + RW'(norm_q >> 1);
          dvs_d  = RW'({norm_q, {FRAC{1'b0}}});
          quo_d  = '0;
          step_d = 5'd1;
        end else begin
          quo_d  = quo_nx;
          rem_d  = cs_ge ? cs_diff : rem_q;
          dvs_d  = dvs_q >> 1;
          step_d = step_q + 5'd1;
          if (step_q == 5'(DIV_STEPS)) begin
            wide_d[comp_q] = wide_q[comp_q][WW-1] ? $signed(-quo_w) : $signed(quo_w);
            step_d         = '0;
            if (comp_q == C_W) begin
              state_d = S_DONE;
            end else begin
              comp_d = comp_q + 2'd1;
            end
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          for (int i = 0; i < 4; i++) begin
            out_d[i]    = sat[i].val;
            orient_d[i] = sat[i].val;
          end
          out_renorm_d = renorm_q;
          out_sat_d    = any_clip;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      term_q      <= '0;
      cap_q       <= '0;
      step_q      <= '0;
      comp_q      <= '0;
      count_q     <= '0;
      interval_q  <= RENORM_RST;
      renorm_q    <= 1'b0;
      out_valid_q <= 1'b0;
      orient_q[C_X] <= '0;
      orient_q[C_Y] <= '0;
      orient_q[C_Z] <= '0;
      orient_q[C_W] <= QONE;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      cap_q       <= cap_d;
      step_q      <= step_d;
      comp_q      <= comp_d;
      count_q     <= count_d;
      interval_q  <= interval_d;
      renorm_q    <= renorm_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < 4; i++) begin
        orient_q[i] <= orient_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    dvs_q        <= dvs_d;
    bit_q        <= bit_d;
    quo_q        <= quo_d;
    norm_q       <= norm_d;
    out_renorm_q <= out_renorm_d;
    out_sat_q    <= out_sat_d;
    for (int i = 0; i < 4; i++) begin
      din_q[i]  <= din_d[i];
      wide_q[i] <= wide_d[i];
      out_q[i]  <= out_d[i];
    end
  end

  // Ports
  assign pready         = 1'b1;
  assign prdata         = (paddr[CFG_AW-1] == REG_RENORM) ? DW'(interval_q) : '0;
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_x_o        = out_q[C_X];
  assign out_y_o        = out_q[C_Y];
  assign out_z_o        = out_q[C_Z];
  assign out_w_o        = out_q[C_W];
  assign renormalized_o = out_renorm_q;
  assign saturated_o    = out_sat_q;

  // An accepted beat always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted beat did not start work");

  // A unit-norm quotient never reaches the clip limits
  a_renorm_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && renormalized_o) |-> !saturated_o)
    else $error("renormalised result was clipped");

  // Divide only runs with a nonzero norm
  a_div_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (norm_q != '0))
    else $error("divide started with zero norm");

  // MAC sums only arrive while the sequencer collects them
  a_mac_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == S_MUL || state_q == S_SQ))
    else $error("MAC sum arrived outside a multiply phase");

endmodule
